>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must never hold outside reset
`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/core/ifop_pkg.sv
package ifop_pkg;

	localparam int CHAR_W       = 8;
	localparam int STATUS_W     = 2;
	localparam int FRAG_W       = 16;
	localparam int OUT_DATA_W   = 24;
	localparam int TOKEN_CNT_W  = 3;
	localparam int MAX_TOKENS_D = 4;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_TOKEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_NUM   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

	localparam logic [FRAG_W-1:0] OFFSET_MAX = 16'd8189;

	typedef struct packed {
		logic       nul;
		logic       sep;
		logic       let_d;
		logic       let_m;
		logic       let_r;
		logic       let_x;
		logic       dec_ok;
		logic       oct_ok;
		logic       hex_ok;
		logic [3:0] digit;
	} cls_t;

endpackage

>>> rtl/core/ifop_front.sv
module ifop_front (
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ifop_pkg::CHAR_W-1:0] s_tdata,   // [7:0] character
	input  logic                        q_full,
	output logic                        push,
	output ifop_pkg::cls_t              item
);

	logic [ifop_pkg::CHAR_W-1:0] c;

	assign c        = s_tdata;
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		item        = '0;
		item.nul    = (c == 8'h00);
		item.sep    = (c == 8'h20) || (c == 8'h2C);
		item.let_d  = (c == 8'h44);
		item.let_m  = (c == 8'h4D);
		item.let_r  = (c == 8'h52);
		item.let_x  = (c == 8'h78) || (c == 8'h58);
		item.dec_ok = (c >= 8'h30) && (c <= 8'h39);
		item.oct_ok = (c >= 8'h30) && (c <= 8'h37);
		if (item.dec_ok) begin
			item.hex_ok = 1'b1;
			item.digit  = 4'(c - 8'h30);
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			item.hex_ok = 1'b1;
			item.digit  = 4'(c - 8'h57);
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			item.hex_ok = 1'b1;
			item.digit  = 4'(c - 8'h37);
		end
	end

endmodule

>>> rtl/core/ifop_queue.sv
module ifop_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ifop_pkg::cls_t push_item,
	input  logic           pop,
	output ifop_pkg::cls_t head,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (ifop_pkg::QUEUE_DEPTH > 1) ? $clog2(ifop_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ifop_pkg::QUEUE_DEPTH + 1);

	ifop_pkg::cls_t           mem_q [ifop_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [CNT_W-1:0]         count_q;

	assign full  = (count_q == CNT_W'(ifop_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ifop_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ifop_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/ifop_back.sv
module ifop_back #(
	parameter int MAX_TOKENS = ifop_pkg::MAX_TOKENS_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ifop_pkg::cls_t                  head,
	input  logic                            q_empty,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ifop_pkg::OUT_DATA_W-1:0] m_tdata   // [1:0] status, [17:2] frag_field
);

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_ZERO   = 3'd1;
	localparam logic [2:0] PH_DEC    = 3'd2;
	localparam logic [2:0] PH_OCT    = 3'd3;
	localparam logic [2:0] PH_HEXPFX = 3'd4;
	localparam logic [2:0] PH_HEX    = 3'd5;
	localparam logic [2:0] PH_BAD    = 3'd6;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam logic [16:0] NUM_SAT = 17'h10000;

	logic                                in_token_q, in_token_d;
	logic [ifop_pkg::TOKEN_CNT_W-1:0]    tokens_q, tokens_d;
	logic                                is_num_q, is_num_d;
	logic [2:0]                          phase_q, phase_d;
	logic [16:0]                         value_q, value_d;
	logic                                seen_d_q, seen_d_d;
	logic                                seen_m_q, seen_m_d;
	logic                                seen_r_q, seen_r_d;
	logic                                seen_o_q, seen_o_d;
	logic [ifop_pkg::FRAG_W-1:0]         offset_q, offset_d;
	logic [ifop_pkg::STATUS_W-1:0]       err_q, err_d;
	logic                                out_valid_q;
	logic [ifop_pkg::STATUS_W-1:0]       out_status_q;
	logic [ifop_pkg::FRAG_W-1:0]         out_frag_q;

	logic                                num_open;
	logic                                end_err;
	logic [2:0]                          nc_phase;
	logic [16:0]                         nc_value;
	logic [ifop_pkg::FRAG_W-1:0]         final_offset;
	logic [ifop_pkg::STATUS_W-1:0]       res_status;
	logic [ifop_pkg::FRAG_W-1:0]         res_frag;

	function automatic logic [16:0] accum(input logic [16:0] v, input logic [1:0] base,
	                                      input logic [3:0] d);
		logic [20:0] w;
		begin
			case (base)
				BASE_DEC: w = (21'(v) << 3) + (21'(v) << 1);
				BASE_OCT: w = 21'(v) << 3;
				default:  w = 21'(v) << 4;
			endcase
			w = w + 21'(d);
			accum = (w > 21'd65535) ? NUM_SAT : w[16:0];
		end
	endfunction

	assign pop      = !q_empty && (!head.nul || !out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_frag_q, out_status_q};

	// number scanner step for the current character
	always_comb begin
		nc_phase = phase_q;
		nc_value = value_q;
		case (phase_q)
			PH_START: begin
				if (head.dec_ok && head.digit == 4'd0) begin
					nc_phase = PH_ZERO;
				end else begin
					nc_phase = PH_DEC;
					nc_value = accum(value_q, BASE_DEC, head.digit);
				end
			end
			PH_ZERO: begin
				if (head.let_x) begin
					nc_phase = PH_HEXPFX;
				end else if (head.oct_ok) begin
					nc_phase = PH_OCT;
					nc_value = accum(value_q, BASE_OCT, head.digit);
				end else begin
					nc_phase = PH_BAD;
				end
			end
			PH_DEC: begin
				if (head.dec_ok) nc_value = accum(value_q, BASE_DEC, head.digit);
				else nc_phase = PH_BAD;
			end
			PH_OCT: begin
				if (head.oct_ok) nc_value = accum(value_q, BASE_OCT, head.digit);
				else nc_phase = PH_BAD;
			end
			PH_HEXPFX, PH_HEX: begin
				if (head.hex_ok) begin
					nc_phase = PH_HEX;
					nc_value = accum(value_q, BASE_HEX, head.digit);
				end else begin
					nc_phase = PH_BAD;
				end
			end
			default: nc_phase = PH_BAD;
		endcase
	end

	assign num_open = in_token_q && is_num_q;
	assign end_err  = num_open && ((phase_q == PH_BAD) || (phase_q == PH_HEXPFX) ||
	                  (phase_q == PH_START) || value_q[16]);
	assign final_offset = num_open ? value_q[15:0] : offset_q;

	always_comb begin
		res_frag = '0;
		if (err_q != ifop_pkg::ST_OK) begin
			res_status = err_q;
		end else if (end_err) begin
			res_status = ifop_pkg::ST_BAD_NUM;
		end else if (final_offset > ifop_pkg::OFFSET_MAX) begin
			res_status = ifop_pkg::ST_RANGE;
		end else begin
			res_status = ifop_pkg::ST_OK;
			res_frag   = {seen_r_q, seen_d_q, seen_m_q, final_offset[12:0]};
		end
	end

	always_comb begin
		in_token_d = in_token_q;
		tokens_d   = tokens_q;
		is_num_d   = is_num_q;
		phase_d    = phase_q;
		value_d    = value_q;
		seen_d_d   = seen_d_q;
		seen_m_d   = seen_m_q;
		seen_r_d   = seen_r_q;
		seen_o_d   = seen_o_q;
		offset_d   = offset_q;
		err_d      = err_q;
		if (pop) begin
			if (head.nul) begin
				in_token_d = 1'b0;
				tokens_d   = '0;
				is_num_d   = 1'b0;
				phase_d    = PH_START;
				value_d    = '0;
				seen_d_d   = 1'b0;
				seen_m_d   = 1'b0;
				seen_r_d   = 1'b0;
				seen_o_d   = 1'b0;
				offset_d   = '0;
				err_d      = ifop_pkg::ST_OK;
			end else if (err_q != ifop_pkg::ST_OK) begin
				err_d = err_q;
			end else if (head.sep) begin
				if (end_err) err_d = ifop_pkg::ST_BAD_NUM;
				else if (num_open) offset_d = value_q[15:0];
				in_token_d = 1'b0;
				is_num_d   = 1'b0;
			end else if (in_token_q) begin
				if (is_num_q) begin
					phase_d = nc_phase;
					value_d = nc_value;
				end
			end else if (tokens_q < ifop_pkg::TOKEN_CNT_W'(MAX_TOKENS)) begin
				tokens_d   = tokens_q + 1'b1;
				in_token_d = 1'b1;
				is_num_d   = 1'b0;
				if (head.let_d) begin
					if (seen_d_q) err_d = ifop_pkg::ST_BAD_TOKEN;
					else seen_d_d = 1'b1;
				end else if (head.let_m) begin
					if (seen_m_q) err_d = ifop_pkg::ST_BAD_TOKEN;
					else seen_m_d = 1'b1;
				end else if (head.let_r) begin
					if (seen_r_q) err_d = ifop_pkg::ST_BAD_TOKEN;
					else seen_r_d = 1'b1;
				end else if (head.dec_ok) begin
					if (seen_o_q) begin
						err_d = ifop_pkg::ST_BAD_TOKEN;
					end else begin
						seen_o_d = 1'b1;
						is_num_d = 1'b1;
						// first digit: zero enters the zero phase, any other digit the decimal phase with its value
						if (head.digit == 4'd0) begin
							phase_d = PH_ZERO;
							value_d = '0;
						end else begin
							phase_d = PH_DEC;
							value_d = 17'(head.digit);
						end
					end
				end else begin
					err_d = ifop_pkg::ST_BAD_TOKEN;
				end
				if (err_d != ifop_pkg::ST_OK) in_token_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q  <= 1'b0;
			tokens_q    <= '0;
			is_num_q    <= 1'b0;
			phase_q     <= PH_START;
			value_q     <= '0;
			seen_d_q    <= 1'b0;
			seen_m_q    <= 1'b0;
			seen_r_q    <= 1'b0;
			seen_o_q    <= 1'b0;
			offset_q    <= '0;
			err_q       <= ifop_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			in_token_q <= in_token_d;
			tokens_q   <= tokens_d;
			is_num_q   <= is_num_d;
			phase_q    <= phase_d;
			value_q    <= value_d;
			seen_d_q   <= seen_d_d;
			seen_m_q   <= seen_m_d;
			seen_r_q   <= seen_r_d;
			seen_o_q   <= seen_o_d;
			offset_q   <= offset_d;
			err_q      <= err_d;
			if (pop && head.nul) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.nul) begin
			out_status_q <= res_status;
			out_frag_q   <= res_frag;
		end
	end

endmodule

>>> rtl/core/ip_fragment_option_parser_top.sv
// channel   dir  tdata                                   transaction
// s_axis    in   [7:0] character                         one text character, 0 ends text
// m_axis    out  [1:0] status, [17:2] frag_field         one result per terminating NUL
//
// One character per cycle sustained while m_axis is not stalled; a character reaches
// the parser through a two-entry queue between classifier and parser.
// A result appears on m_axis the cycle after its NUL leaves the queue.
// arst_n clears the queue, the parser state and the output valid flag, not the output data.
// A stalled m_axis holds the next NUL at the queue head; characters behind it
// wait, and s_tready drops once the queue is full.
`include "assert_macros.svh"

module ip_fragment_option_parser_top #(
	parameter int MAX_TOKENS = ifop_pkg::MAX_TOKENS_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ifop_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] character
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ifop_pkg::OUT_DATA_W-1:0] m_tdata    // [1:0] status, [17:2] frag_field
);

	ifop_pkg::cls_t     push_item;
	ifop_pkg::cls_t     head;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;

	ifop_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (q_push),
		.item     (push_item)
	);

	ifop_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	ifop_back #(
		.MAX_TOKENS (MAX_TOKENS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`CHK_IMPL(a_err_clears_frag, m_tvalid && (m_tdata[1:0] != ifop_pkg::ST_OK), m_tdata[17:2] == 16'd0, "frag_field set with error status")
	`CHK_IMPL(a_ok_in_range, m_tvalid && (m_tdata[1:0] == ifop_pkg::ST_OK), m_tdata[14:2] <= 13'd8189, "offset above limit with ok status")
	`CHK_NEVER(a_no_overwrite, m_tvalid && !m_tready && q_pop && head.nul, "result overwritten while stalled")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int IDLE_PCT    = 34;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 16;
	localparam int CYCLE_LIMIT = 100000;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [2:0] {
		NP_START, NP_ZERO, NP_DEC, NP_OCT, NP_HEXPFX, NP_HEX, NP_BAD
	} num_phase_t;

	typedef struct {
		logic [ifop_pkg::STATUS_W-1:0] status;
		logic [ifop_pkg::FRAG_W-1:0]   frag;
	} frag_result_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ifop_pkg::CHAR_W-1:0]     s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ifop_pkg::OUT_DATA_W-1:0] m_tdata;

	int idle_pct   = IDLE_PCT;
	int hold_left  = 0;
	int cycles     = 0;
	int mismatches = 0;

	frag_result_t frag_expected[$];

	// parser state mirror
	logic                             tok_open;
	logic [ifop_pkg::TOKEN_CNT_W-1:0] tok_count;
	logic                             tok_numeric;
	num_phase_t                       num_phase;
	logic [16:0]                      num_val;
	logic                             flag_df, flag_mf, flag_rf;
	logic                             offset_seen;
	logic [ifop_pkg::FRAG_W-1:0]      offset_val;
	logic [ifop_pkg::STATUS_W-1:0]    first_err;

	ip_fragment_option_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic void clear_parser();
		tok_open    = 1'b0;
		tok_count   = '0;
		tok_numeric = 1'b0;
		num_phase   = NP_START;
		num_val     = '0;
		flag_df     = 1'b0;
		flag_mf     = 1'b0;
		flag_rf     = 1'b0;
		offset_seen = 1'b0;
		offset_val  = '0;
		first_err   = ifop_pkg::ST_OK;
	endfunction

	function automatic void num_acc(input int base, input int d);
		int v;
		v = int'(num_val) * base + d;
		num_val = (v > 65535) ? 17'd65536 : 17'(v);
	endfunction

	function automatic void num_step(input logic [7:0] c);
		int hv;
		hv = -1;
		if (c >= "0" && c <= "9") hv = c - "0";
		else if (c >= "a" && c <= "f") hv = c - "a" + 10;
		else if (c >= "A" && c <= "F") hv = c - "A" + 10;
		case (num_phase)
			NP_START: begin
				if (c == "0") num_phase = NP_ZERO;
				else begin
					num_phase = NP_DEC;
					num_acc(10, hv);
				end
			end
			NP_ZERO: begin
				if (c == "x" || c == "X") num_phase = NP_HEXPFX;
				else if (c >= "0" && c <= "7") begin
					num_phase = NP_OCT;
					num_acc(8, hv);
				end else num_phase = NP_BAD;
			end
			NP_DEC: begin
				if (c >= "0" && c <= "9") num_acc(10, hv);
				else num_phase = NP_BAD;
			end
			NP_OCT: begin
				if (c >= "0" && c <= "7") num_acc(8, hv);
				else num_phase = NP_BAD;
			end
			NP_HEXPFX, NP_HEX: begin
				if (hv >= 0) begin
					num_phase = NP_HEX;
					num_acc(16, hv);
				end else num_phase = NP_BAD;
			end
			default: num_phase = NP_BAD;
		endcase
	endfunction

	function automatic void end_token();
		if (tok_open && tok_numeric) begin
			if (num_phase == NP_BAD || num_phase == NP_HEXPFX || num_phase == NP_START ||
					num_val > 17'd65535)
				first_err = ifop_pkg::ST_BAD_NUM;
			else
				offset_val = num_val[15:0];
		end
		tok_open    = 1'b0;
		tok_numeric = 1'b0;
	endfunction

	function automatic void start_token(input logic [7:0] c);
		tok_count   = tok_count + 1'b1;
		tok_open    = 1'b1;
		tok_numeric = 1'b0;
		if (c == "D") begin
			if (flag_df) first_err = ifop_pkg::ST_BAD_TOKEN;
			else flag_df = 1'b1;
		end else if (c == "M") begin
			if (flag_mf) first_err = ifop_pkg::ST_BAD_TOKEN;
			else flag_mf = 1'b1;
		end else if (c == "R") begin
			if (flag_rf) first_err = ifop_pkg::ST_BAD_TOKEN;
			else flag_rf = 1'b1;
		end else if (c >= "0" && c <= "9") begin
			if (offset_seen) first_err = ifop_pkg::ST_BAD_TOKEN;
			else begin
				offset_seen = 1'b1;
				tok_numeric = 1'b1;
				num_phase   = NP_START;
				num_val     = '0;
				num_step(c);
			end
		end else first_err = ifop_pkg::ST_BAD_TOKEN;
		if (first_err != ifop_pkg::ST_OK) tok_open = 1'b0;
	endfunction

	// advances the mirror by one accepted character; a NUL queues the fragment word
	function automatic void parse_char(input logic [7:0] c);
		frag_result_t r;
		if (c == 8'h00) begin
			r.frag = '0;
			if (first_err == ifop_pkg::ST_OK) end_token();
			if (first_err != ifop_pkg::ST_OK) r.status = first_err;
			else if (offset_val > ifop_pkg::OFFSET_MAX) r.status = ifop_pkg::ST_RANGE;
			else begin
				r.status = ifop_pkg::ST_OK;
				r.frag   = {flag_rf, flag_df, flag_mf, offset_val[12:0]};
			end
			frag_expected.push_back(r);
			clear_parser();
		end else if (first_err == ifop_pkg::ST_OK) begin
			if (c == " " || c == ",") end_token();
			else if (tok_open) begin
				if (tok_numeric) num_step(c);
			end else if (tok_count < ifop_pkg::MAX_TOKENS_D) start_token(c);
		end
	endfunction

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		parse_char(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
		send_char(8'h00);
	endtask

	function automatic logic [7:0] noise_char();
		return 8'($urandom_range(255, 1));
	endfunction

	// any nonzero byte except the separators
	function automatic logic [7:0] token_char();
		logic [7:0] c;
		c = noise_char();
		if (c == " " || c == ",") c = "_";
		return c;
	endfunction

	function automatic string make_gap(input int min_n);
		string s;
		int n;
		s = "";
		n = $urandom_range(2, min_n);
		for (int i = 0; i < n; i++) s = {s, ($urandom_range(1) != 0) ? " " : ","};
		return s;
	endfunction

	function automatic string letter_token(input logic [7:0] l);
		string s;
		int n;
		s = $sformatf("%c", l);
		n = $urandom_range(3);
		for (int i = 0; i < n; i++) s = {s, $sformatf("%c", token_char())};
		return s;
	endfunction

	function automatic string make_number();
		int unsigned v;
		string s;
		case ($urandom_range(6))
			0: v = $urandom_range(15);
			1: v = $urandom_range(8195, 8180);
			2: v = $urandom_range(8189);
			3: v = $urandom_range(65535);
			4: v = $urandom_range(70000, 65530);
			5: v = $urandom;
			default: v = $urandom_range(8189);
		endcase
		case ($urandom_range(3))
			0: s = $sformatf("0%0o", v);
			1: s = $sformatf("0x%0h", v);
			2: s = $sformatf("0X%0h", v);
			default: s = $sformatf("%0d", v);
		endcase
		for (int i = 0; i < s.len(); i++)
			if (s[i] >= "a" && s[i] <= "f" && $urandom_range(1) != 0) s.putc(i, s[i] - 8'd32);
		if ($urandom_range(99) < 12) begin
			case ($urandom_range(3))
				0: s = ($urandom_range(1) != 0) ? "0x" : "0X";
				1: s = "09";
				2: s = "0xg";
				default: s = {s, $sformatf("%c", token_char())};
			endcase
		end
		return s;
	endfunction

	// mostly well-formed option strings, some broken, some pure noise
	function automatic string make_text();
		string toks[$];
		string s;
		int n;
		s = "";
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(10);
			for (int i = 0; i < n; i++) s = {s, $sformatf("%c", noise_char())};
			return s;
		end
		if ($urandom_range(99) < 60) toks.insert($urandom_range(toks.size()), letter_token("D"));
		if ($urandom_range(99) < 60) toks.insert($urandom_range(toks.size()), letter_token("M"));
		if ($urandom_range(99) < 60) toks.insert($urandom_range(toks.size()), letter_token("R"));
		if ($urandom_range(99) < 75) toks.insert($urandom_range(toks.size()), make_number());
		if ($urandom_range(99) < 10) begin
			case ($urandom_range(3))
				0: toks.insert($urandom_range(toks.size()), letter_token("D"));
				1: toks.insert($urandom_range(toks.size()), letter_token("M"));
				2: toks.insert($urandom_range(toks.size()), letter_token("R"));
				default: toks.insert($urandom_range(toks.size()), make_number());
			endcase
		end
		if ($urandom_range(99) < 10) toks.push_back(letter_token(token_char()));
		s = make_gap(0);
		foreach (toks[i]) s = {s, toks[i], (i == toks.size() - 1) ? make_gap(0) : make_gap(1)};
		if (s.len() > 0 && $urandom_range(99) < 12) s.putc($urandom_range(s.len() - 1), noise_char());
		return s;
	endfunction

	task automatic test_flags_offset();
		send_text("");
		send_text("R,D M 0x1FFD");
		send_text("M 7 D R,\377");
	endtask

	task automatic test_number_faults();
		send_text("8190");
		send_text("0x");
		send_text("65536");
		send_text("09");
	endtask

	task automatic test_token_faults();
		send_text("M M");
		send_text("\377");
		send_text("D 1 2");
	endtask

	// output held off while the sender keeps pushing short texts
	task automatic test_output_stall();
		s_tvalid <= 1'b0;
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		idle_pct  = 0;
		@(posedge clk);
		for (int k = 0; k < 30; k++) begin
			case (k % 3)
				0: send_text("");
				1: send_text("D");
				default: send_text("42");
			endcase
		end
		idle_pct = IDLE_PCT;
	endtask

	task automatic test_random_text();
		string s;
		int chars;
		int texts;
		chars = 0;
		texts = 0;
		idle_pct = 0;
		while (chars < 340 || texts < 40) begin
			if (chars >= 120) idle_pct = IDLE_PCT;
			s = make_text();
			send_text(s);
			chars += s.len() + 1;
			texts++;
		end
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else m_tready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic note_mismatch(input string what, input int exp_v, input int act_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		frag_result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (frag_expected.size() == 0) note_mismatch("unexpected transaction", 0, m_tdata);
			else begin
				r = frag_expected.pop_front();
				if (m_tdata[1:0] != r.status) note_mismatch("status", r.status, m_tdata[1:0]);
				if (m_tdata[17:2] != r.frag) note_mismatch("frag_field", r.frag, m_tdata[17:2]);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** ip_fragment_option_parser_top: FAILED **");
			$finish;
		end
	end

	initial begin
		clear_parser();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_flags_offset();
		test_number_faults();
		test_token_faults();
		test_output_stall();
		test_random_text();
		s_tvalid <= 1'b0;
		while (frag_expected.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0) begin
			$display("** ip_fragment_option_parser_top: PASSED **");
		end else begin
			$display("** ip_fragment_option_parser_top: FAILED **");
		end
		$finish;
	end

endmodule
